>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shapes for the checkers of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ipatp_pkg.sv
// ----------------------------------------------------------------------------
// ipatp_pkg
// Types and constants shared by the address text parser modules.
// ----------------------------------------------------------------------------
package ipatp_pkg;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        is_ipv6;
      logic [7:0]  prefix_len;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
   } rsp_type;

   // One character after classification.
   typedef struct packed {
      logic       last;
      logic       is_dec;
      logic       is_hex;
      logic [3:0] nib;
      logic       is_dot;
      logic       is_colon;
      logic       is_slash;
   } char_class_type;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_DOT     = 8'h2e;
   localparam logic [7:0] CHAR_COLON   = 8'h3a;
   localparam logic [7:0] CHAR_SLASH   = 8'h2f;
   localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;

   localparam int unsigned MIN_TEXT_LEN = 2;

   localparam logic [7:0]  PREFIX_MAX        = 8'd128;
   localparam logic [7:0]  PREFIX_SAT        = 8'd129;
   localparam logic [7:0]  V4_PREFIX_DEFAULT = 8'd32;
   localparam logic [7:0]  V6_PREFIX_DEFAULT = 8'd128;
   localparam logic [8:0]  V4_FIELD_MAX      = 9'd255;
   localparam logic [8:0]  V4_FIELD_SAT      = 9'd256;
   localparam logic [1:0]  V4_LAST_FIELD     = 2'd3;
   localparam logic [16:0] V6_GROUP_MAX      = 17'h0ffff;
   localparam logic [16:0] V6_GROUP_SAT      = 17'h10000;
   localparam logic [3:0]  V6_GROUPS         = 4'd8;

endpackage

>>> sv/ip_address_text_parser.sv
// ----------------------------------------------------------------------------
// ip_address_text_parser
// IPv4 / IPv6 address text parser with optional prefix, one character per item.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_ready  req_type: char_code, last_char
//   rsp_     out        rsp_valid / rsp_ready  rsp_type: accepted .. addr_low
//
// One character is taken every cycle while the queue has room; the back end
// updates all accumulators for a character together. A result turns valid when
// its final character leaves the queue for the back end; its valid is registered.
// Reset clears the queue, the accumulators and the result valid.
// An unclaimed result holds the next final character in the two-entry queue;
// req_ready falls once that character and one more are waiting.
module ip_address_text_parser
   import ipatp_pkg::*;
#(
   parameter int unsigned MAX_TEXT_LEN = 43
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   char_class_type front_cls;
   char_class_type back_item;
   logic           back_valid;
   logic           back_ready;

   ipatp_front u_front (
      .req_item (req_item),
      .cls      (front_cls)
   );

   ipatp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_valid),
      .wr_ready (req_ready),
      .wr_item  (front_cls),
      .rd_valid (back_valid),
      .rd_ready (back_ready),
      .rd_item  (back_item)
   );

   ipatp_back #(
      .MAX_TEXT_LEN (MAX_TEXT_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .item       (back_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule

>>> sv/ipatp_front.sv
// ----------------------------------------------------------------------------
// ipatp_front
// Classifies one incoming character into digit, hex and separator classes.
// ----------------------------------------------------------------------------
module ipatp_front
   import ipatp_pkg::*;
(
   input  req_type        req_item,
   output char_class_type cls
);

   logic [7:0] c;
   logic       is_lower;
   logic       is_upper;

   assign c        = req_item.char_code;
   assign is_lower = (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F);
   assign is_upper = (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F);

   always_comb begin
      cls.last     = req_item.last_char;
      cls.is_dec   = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      cls.is_hex   = cls.is_dec || is_lower || is_upper;
      // Letters a..f and A..F carry their value in the low nibble plus nine.
      cls.nib      = cls.is_dec ? c[3:0] : c[3:0] + HEX_LETTER_OFFSET;
      cls.is_dot   = (c == CHAR_DOT);
      cls.is_colon = (c == CHAR_COLON);
      cls.is_slash = (c == CHAR_SLASH);
   end

endmodule

>>> sv/ipatp_queue.sv
// ----------------------------------------------------------------------------
// ipatp_queue
// Two-entry queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module ipatp_queue
   import ipatp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_valid,
   output logic           wr_ready,
   input  char_class_type wr_item,
   output logic           rd_valid,
   input  logic           rd_ready,
   output char_class_type rd_item
);

   char_class_type entry_ff [2];
   logic           wr_ptr_ff;
   logic           wr_ptr_in;
   logic           rd_ptr_ff;
   logic           rd_ptr_in;
   logic [1:0]     count_ff;
   logic [1:0]     count_in;
   logic           do_wr;
   logic           do_rd;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_item  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

>>> sv/ipatp_back.sv
// ----------------------------------------------------------------------------
// ipatp_back
// Runs the IPv4, IPv6 and prefix accumulators and registers the result.
// ----------------------------------------------------------------------------
module ipatp_back
   import ipatp_pkg::*;
#(
   parameter int unsigned MAX_TEXT_LEN = 43
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           item_valid,
   output logic           item_ready,
   input  char_class_type item,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_item
);

   localparam int unsigned COUNT_W = $clog2(MAX_TEXT_LEN + 2);

   typedef struct packed {
      logic digit;
      logic err;
      logic gap;
      logic colon;
      logic lead;
   } v6_flags_type;

   logic [COUNT_W-1:0] char_count_ff, char_count_in;
   logic               in_prefix_ff, in_prefix_in;
   logic [7:0]         prefix_value_ff, prefix_value_in;
   logic               prefix_digit_ff, prefix_digit_in;
   logic               prefix_err_ff, prefix_err_in;
   logic [1:0]         v4_index_ff, v4_index_in;
   logic [8:0]         v4_value_ff, v4_value_in;
   logic               v4_digit_ff, v4_digit_in;
   logic               v4_err_ff, v4_err_in;
   logic [23:0]        v4_addr_ff, v4_addr_in;
   logic [16:0]        v6_value_ff, v6_value_in;
   v6_flags_type       v6_flags_ff, v6_flags_in;
   logic [3:0]         v6_count_ff, v6_count_in;
   logic [127:0]       v6_head_ff, v6_head_in;
   logic [127:0]       v6_tail_ff, v6_tail_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_item_ff, rsp_item_in;

   logic [11:0]        prefix_calc;
   logic [11:0]        v4_calc;
   logic [20:0]        v6_calc;
   logic               colon_commit;
   logic               commit_en;
   logic [2:0]         head_slot;
   logic               advance;
   logic               len_ok;
   logic               pre_ok;
   logic               v4_ok;
   logic               v6_ok;
   logic [7:0]         v4_plen;

   // A final character waits while an earlier result is still unclaimed.
   assign item_ready = !item.last || !rsp_valid_ff || rsp_ready;
   assign advance    = item_valid && item_ready;

   always_comb begin
      char_count_in   = char_count_ff;
      in_prefix_in    = in_prefix_ff;
      prefix_value_in = prefix_value_ff;
      prefix_digit_in = prefix_digit_ff;
      prefix_err_in   = prefix_err_ff;
      v4_index_in     = v4_index_ff;
      v4_value_in     = v4_value_ff;
      v4_digit_in     = v4_digit_ff;
      v4_err_in       = v4_err_ff;
      v4_addr_in      = v4_addr_ff;
      v6_value_in     = v6_value_ff;
      v6_flags_in     = v6_flags_ff;
      v6_count_in     = v6_count_ff;
      v6_head_in      = v6_head_ff;
      v6_tail_in      = v6_tail_ff;
      colon_commit    = 1'b0;

      prefix_calc = 12'({prefix_value_ff, 3'b000}) + 12'({prefix_value_ff, 1'b0})
                    + 12'(item.nib);
      v4_calc     = 12'({v4_value_ff, 3'b000}) + 12'({v4_value_ff, 1'b0})
                    + 12'(item.nib);
      v6_calc     = {v6_value_ff, item.nib};

      if (char_count_ff < COUNT_W'(MAX_TEXT_LEN + 1)) begin
         char_count_in = char_count_ff + 1'b1;
      end

      if (in_prefix_ff) begin
         if (item.is_dec) begin
            prefix_value_in = (prefix_calc > 12'(PREFIX_MAX)) ? PREFIX_SAT
                                                               : prefix_calc[7:0];
            prefix_digit_in = 1'b1;
         end else begin
            prefix_err_in = 1'b1;
         end
      end else if (item.is_slash) begin
         in_prefix_in = 1'b1;
      end else begin
         // Dotted decimal path.
         if (!v4_err_ff) begin
            if (item.is_dec) begin
               v4_value_in = (v4_calc > 12'(V4_FIELD_MAX)) ? V4_FIELD_SAT : v4_calc[8:0];
               v4_digit_in = 1'b1;
            end else if (item.is_dot && v4_digit_ff && (v4_value_ff <= V4_FIELD_MAX)
                         && (v4_index_ff < V4_LAST_FIELD)) begin
               v4_addr_in  = {v4_addr_ff[15:0], v4_value_ff[7:0]};
               v4_index_in = v4_index_ff + 1'b1;
               v4_value_in = '0;
               v4_digit_in = 1'b0;
               v4_err_in   = 1'b0;
            end else begin
               v4_err_in = 1'b1;
            end
         end
         // Hex group path; the group commit itself happens below.
         if (!v6_flags_ff.err) begin
            if (item.is_hex) begin
               if (v6_flags_ff.lead) begin
                  v6_flags_in.err = 1'b1;
               end else begin
                  v6_value_in       = v6_calc[20:16] != '0 ? V6_GROUP_SAT : v6_calc[16:0];
                  v6_flags_in.colon = 1'b0;
                  v6_flags_in.digit = 1'b1;
               end
            end else if (item.is_colon) begin
               if (v6_flags_ff.digit) begin
                  colon_commit = 1'b1;
               end else if (v6_flags_ff.colon || v6_flags_ff.lead) begin
                  if (v6_flags_ff.gap) begin
                     v6_flags_in.err = 1'b1;
                  end else begin
                     v6_flags_in.colon = 1'b0;
                     v6_flags_in.lead  = 1'b0;
                     v6_flags_in.gap   = 1'b1;
                  end
               end else if (v6_flags_ff.gap) begin
                  v6_flags_in.err = 1'b1;
               end else begin
                  v6_flags_in.lead = 1'b1;
               end
            end else begin
               v6_flags_in.err = 1'b1;
            end
         end
      end

      // A group closes on a colon, or at the end of the text if one is open.
      // Both can happen for a final colon; the group then closes once, so one commit unit serves.
      commit_en = colon_commit || (item.last && v6_flags_in.digit);
      head_slot = 3'd7 - v6_count_in[2:0];
      if (commit_en) begin
         if ((v6_count_in >= V6_GROUPS) || (v6_value_in > V6_GROUP_MAX)) begin
            v6_flags_in.err = 1'b1;
         end else begin
            if (v6_flags_in.gap) begin
               v6_tail_in = {v6_tail_in[111:0], v6_value_in[15:0]};
            end else begin
               v6_head_in[head_slot*16 +: 16] = v6_head_in[head_slot*16 +: 16]
                                                | v6_value_in[15:0];
            end
            v6_count_in       = v6_count_in + 1'b1;
            v6_value_in       = '0;
            v6_flags_in.digit = 1'b0;
            if (colon_commit) begin
               v6_flags_in.colon = 1'b1;
            end
         end
      end
   end

   always_comb begin
      len_ok  = (char_count_in >= COUNT_W'(MIN_TEXT_LEN))
                && (char_count_in <= COUNT_W'(MAX_TEXT_LEN));
      pre_ok  = !in_prefix_in
                || (prefix_digit_in && !prefix_err_in && (prefix_value_in <= PREFIX_MAX));
      v4_ok   = !v4_err_in && v4_digit_in && (v4_index_in == V4_LAST_FIELD)
                && (v4_value_in <= V4_FIELD_MAX);
      v4_plen = in_prefix_in ? prefix_value_in : V4_PREFIX_DEFAULT;
      v6_ok   = !v6_flags_in.err && !v6_flags_in.lead
                && (v6_flags_in.gap || v6_flags_in.colon || v6_flags_in.digit
                    || (v6_count_in != '0));

      rsp_item_in = '0;
      if (len_ok && pre_ok) begin
         if (v4_ok) begin
            if (v4_plen <= V4_PREFIX_DEFAULT) begin
               rsp_item_in.accepted   = 1'b1;
               rsp_item_in.prefix_len = v4_plen;
               rsp_item_in.addr_low   = {32'd0, v4_addr_in, v4_value_in[7:0]};
            end
         end else if (v6_ok) begin
            rsp_item_in.accepted   = 1'b1;
            rsp_item_in.is_ipv6    = 1'b1;
            rsp_item_in.prefix_len = in_prefix_in ? prefix_value_in : V6_PREFIX_DEFAULT;
            rsp_item_in.addr_high  = v6_head_in[127:64] | v6_tail_in[127:64];
            rsp_item_in.addr_low   = v6_head_in[63:0] | v6_tail_in[63:0];
         end
      end

      if (advance && item.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && item.last)) begin
         char_count_ff   <= '0;
         in_prefix_ff    <= 1'b0;
         prefix_value_ff <= '0;
         prefix_digit_ff <= 1'b0;
         prefix_err_ff   <= 1'b0;
         v4_index_ff     <= '0;
         v4_value_ff     <= '0;
         v4_digit_ff     <= 1'b0;
         v4_err_ff       <= 1'b0;
         v4_addr_ff      <= '0;
         v6_value_ff     <= '0;
         v6_flags_ff     <= '0;
         v6_count_ff     <= '0;
         v6_head_ff      <= '0;
         v6_tail_ff      <= '0;
      end else if (advance) begin
         char_count_ff   <= char_count_in;
         in_prefix_ff    <= in_prefix_in;
         prefix_value_ff <= prefix_value_in;
         prefix_digit_ff <= prefix_digit_in;
         prefix_err_ff   <= prefix_err_in;
         v4_index_ff     <= v4_index_in;
         v4_value_ff     <= v4_value_in;
         v4_digit_ff     <= v4_digit_in;
         v4_err_ff       <= v4_err_in;
         v4_addr_ff      <= v4_addr_in;
         v6_value_ff     <= v6_value_in;
         v6_flags_ff     <= v6_flags_in;
         v6_count_ff     <= v6_count_in;
         v6_head_ff      <= v6_head_in;
         v6_tail_ff      <= v6_tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item.last) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> sv/ipatp_checker.sv
// ----------------------------------------------------------------------------
// ipatp_checker
// Port-level checks on the result channel of the address text parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipatp_checker
   import ipatp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_item
);

   logic rsp_stall;
   logic reject_zero;
   logic v4_shape;
   logic v6_prefix;

   assign rsp_stall = rsp_valid && !rsp_ready;

   // A rejected text carries all-zero fields.
   assign reject_zero = !rsp_valid || rsp_item.accepted
                        || (!rsp_item.is_ipv6 && (rsp_item.prefix_len == 8'd0)
                            && (rsp_item.addr_high == 64'd0)
                            && (rsp_item.addr_low == 64'd0));

   // An IPv4 result fits in the low 32 bits and has a prefix of at most 32.
   assign v4_shape = !rsp_valid || !rsp_item.accepted || rsp_item.is_ipv6
                     || ((rsp_item.addr_high == 64'd0) && (rsp_item.addr_low[63:32] == 32'd0)
                         && (rsp_item.prefix_len <= V4_PREFIX_DEFAULT));

   assign v6_prefix = !rsp_valid || !rsp_item.is_ipv6
                      || (rsp_item.accepted && (rsp_item.prefix_len <= V6_PREFIX_DEFAULT));

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_item), "unstable result")

   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "result valid right after reset")

   `ASSERT_ALWAYS(a_reject_zero, clock, reset, reject_zero, "rejected item has nonzero fields")

   `ASSERT_ALWAYS(a_v4_shape, clock, reset, v4_shape, "malformed IPv4 item")

   `ASSERT_ALWAYS(a_v6_prefix, clock, reset, v6_prefix, "malformed IPv6 item")

endmodule

bind ip_address_text_parser ipatp_checker u_ipatp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

>>> tb/sv/ip_address_text_parser_tb.sv
// ----------------------------------------------------------------------------
// ip_address_text_parser_tb
// Streams IPv4 and IPv6 address texts, with and without a prefix, into the
// parser one character per item and checks every result against a local
// parser model. Directed texts cover the edges; random, mostly well-formed,
// damaged and noise texts follow, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ip_address_text_parser_tb;
   import ipatp_pkg::*;

   localparam int TEXT_LIMIT   = 43;
   localparam int IDLE_PCT     = 7;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam string HEX_CHARS = "0123456789abcdef";

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   rsp_type pending_results[$];
   int      mismatches = 0;
   int      chars_sent = 0;
   int      idle_cycles = 0;
   bit      no_idle = 1'b0;

   // Parser model state.
   int          text_len;
   bit          in_pfx, pfx_digit, pfx_err;
   int          pfx_val;
   int          v4_idx, v4_fld;
   bit          v4_digit, v4_err;
   logic [31:0] v4_word;
   int          grp_val, grp_cnt;
   bit          g_digit, g_err, g_gap, g_colon, g_lead;
   logic [63:0] head_hi, head_lo, tail_hi, tail_lo;

   ip_address_text_parser #(.MAX_TEXT_LEN(TEXT_LIMIT)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always #4 clock = ~clock;

   function automatic void clear_parser();
      text_len = 0; in_pfx = 0; pfx_val = 0; pfx_digit = 0; pfx_err = 0;
      v4_idx = 0; v4_fld = 0; v4_digit = 0; v4_err = 0; v4_word = '0;
      grp_val = 0; grp_cnt = 0;
      g_digit = 0; g_err = 0; g_gap = 0; g_colon = 0; g_lead = 0;
      head_hi = '0; head_lo = '0; tail_hi = '0; tail_lo = '0;
   endfunction

   // Closes the current hex group. Groups after the gap shift in at the
   // bottom of the tail words so that they end up at the end of the address.
   function automatic void v6_close_group();
      if (grp_cnt >= 8 || grp_val > 'hffff) begin
         g_err = 1;
         return;
      end
      if (g_gap) begin
         tail_hi = {tail_hi[47:0], tail_lo[63:48]};
         tail_lo = {tail_lo[47:0], 16'(grp_val)};
      end else if (grp_cnt < 4) begin
         head_hi |= 64'(grp_val) << ((3 - grp_cnt) * 16);
      end else begin
         head_lo |= 64'(grp_val) << ((7 - grp_cnt) * 16);
      end
      grp_cnt++;
      grp_val = 0;
      g_digit = 0;
   endfunction

   function automatic bit parse_char(input req_type it, output rsp_type res);
      logic [7:0] c;
      int         digit, nib, plen;
      bit         len_ok, pfx_ok, v4_ok, v6_ok;
      c = it.char_code;
      res = '0;
      digit = (c >= CHAR_ZERO && c <= CHAR_NINE) ? int'(c - CHAR_ZERO) : -1;
      if (digit >= 0) nib = digit;
      else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) nib = int'(c - CHAR_LOWER_A) + 10;
      else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) nib = int'(c - CHAR_UPPER_A) + 10;
      else nib = -1;

      if (text_len < TEXT_LIMIT + 1) text_len++;
      if (in_pfx) begin
         if (digit >= 0) begin
            pfx_val = pfx_val * 10 + digit;
            if (pfx_val > 128) pfx_val = 129;
            pfx_digit = 1;
         end else begin
            pfx_err = 1;
         end
      end else if (c == CHAR_SLASH) begin
         in_pfx = 1;
      end else begin
         if (!v4_err) begin
            if (digit >= 0) begin
               v4_fld = v4_fld * 10 + digit;
               if (v4_fld > 255) v4_fld = 256;
               v4_digit = 1;
            end else if (c == CHAR_DOT && v4_digit && v4_fld <= 255 && v4_idx < 3) begin
               v4_word = {v4_word[23:0], 8'(v4_fld)};
               v4_idx++;
               v4_fld = 0;
               v4_digit = 0;
            end else begin
               v4_err = 1;
            end
         end
         if (!g_err) begin
            if (nib >= 0) begin
               // A hex digit right after a single leading colon is malformed.
               if (g_lead) begin
                  g_err = 1;
               end else begin
                  grp_val = (grp_val << 4) | nib;
                  if (grp_val > 'hffff) grp_val = 'h10000;
                  g_colon = 0;
                  g_digit = 1;
               end
            end else if (c == CHAR_COLON) begin
               if (g_digit) begin
                  v6_close_group();
                  if (!g_err) g_colon = 1;
               end else if (g_colon || g_lead) begin
                  if (g_gap) begin
                     g_err = 1;
                  end else begin
                     g_colon = 0;
                     g_lead = 0;
                     g_gap = 1;
                  end
               end else if (g_gap) begin
                  g_err = 1;
               end else begin
                  g_lead = 1;
               end
            end else begin
               g_err = 1;
            end
         end
      end
      if (!it.last_char) return 0;

      len_ok = text_len >= 2 && text_len <= TEXT_LIMIT;
      pfx_ok = !in_pfx || (pfx_digit && !pfx_err && pfx_val <= 128);
      v4_ok = !v4_err && v4_digit && v4_idx == 3 && v4_fld <= 255;
      if (len_ok && pfx_ok) begin
         if (v4_ok) begin
            // A valid IPv4 text with too long a prefix is not retried as IPv6.
            plen = in_pfx ? pfx_val : 32;
            if (plen <= 32) begin
               res.accepted = 1'b1;
               res.prefix_len = 8'(plen);
               res.addr_low = {32'd0, v4_word[23:0], 8'(v4_fld)};
            end
         end else begin
            if (g_digit) v6_close_group();
            v6_ok = !g_err && !g_lead && (g_gap || g_colon || g_digit || grp_cnt > 0);
            if (v6_ok) begin
               res.accepted = 1'b1;
               res.is_ipv6 = 1'b1;
               res.prefix_len = in_pfx ? 8'(pfx_val) : 8'd128;
               res.addr_high = head_hi | tail_hi;
               res.addr_low = head_lo | tail_lo;
            end
         end
      end
      clear_parser();
      return 1;
   endfunction

   task automatic send_char(input logic [7:0] code, input bit last);
      req_type it;
      rsp_type res;
      it.char_code = code;
      it.last_char = last;
      if (!no_idle) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
      if (parse_char(it, res)) pending_results.push_back(res);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] random_char();
      string alphabet = "0123456789abcdefABCDEF.:/ +x";
      if ($urandom_range(1)) return alphabet[$urandom_range(alphabet.len() - 1)];
      return 8'($urandom_range(255, 1));
   endfunction

   function automatic string with_prefix(input string s, input int max_len);
      string p;
      if ($urandom_range(1)) return s;
      p = ($urandom_range(5) == 0) ? "/0" : "/";
      return {s, p, $sformatf("%0d", $urandom_range(max_len))};
   endfunction

   function automatic string make_ipv4_text();
      string s;
      int    v;
      s = "";
      for (int f = 0; f < 4; f++) begin
         v = ($urandom_range(9) == 0) ? $urandom_range(999) : $urandom_range(255);
         if ($urandom_range(7) == 0) s = {s, "0"};
         s = {s, $sformatf("%0d", v)};
         if (f < 3) s = {s, "."};
      end
      return s;
   endfunction

   function automatic string make_ipv6_text();
      string      s;
      int         groups, gap_at, ndig, nib;
      logic [7:0] ch;
      s = "";
      gap_at = -1;
      if ($urandom_range(1)) begin
         groups = $urandom_range(8);
         gap_at = $urandom_range(groups);
      end else begin
         groups = $urandom_range(8, 1);
      end
      if ($urandom_range(15) == 0) groups++;
      for (int g = 0; g < groups; g++) begin
         if (g == gap_at) s = {s, "::"};
         else if (g > 0) s = {s, ":"};
         ndig = ($urandom_range(19) == 0) ? 5 : $urandom_range(4, 1);
         for (int d = 0; d < ndig; d++) begin
            nib = $urandom_range(15);
            ch = HEX_CHARS[nib];
            if (nib > 9 && $urandom_range(1)) ch = ch - 8'h20;
            s = {s, $sformatf("%c", ch)};
         end
      end
      if (gap_at == groups) s = {s, "::"};
      else if (gap_at < 0 && $urandom_range(9) == 0) s = {s, ":"};
      return s;
   endfunction

   function automatic string damage_text(input string s);
      int pos;
      pos = $urandom_range(s.len() - 1);
      case ($urandom_range(2))
         0: s.putc(pos, random_char());
         1: s = {s.substr(0, pos - 1), s.substr(pos + 1, s.len() - 1)};
         default: s = {s.substr(0, pos - 1), $sformatf("%c", random_char()),
                       s.substr(pos, s.len() - 1)};
      endcase
      return s;
   endfunction

   task automatic run_random_texts(input int char_budget);
      int    stop_at, pick, n;
      string s;
      stop_at = chars_sent + char_budget;
      while (chars_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            s = with_prefix(make_ipv4_text(), 40);
         end else if (pick < 80) begin
            s = with_prefix(make_ipv6_text(), 140);
         end else begin
            s = "";
            n = $urandom_range(50, 1);
            repeat (n) s = {s, $sformatf("%c", random_char())};
         end
         if (pick < 80 && $urandom_range(3) == 0) s = damage_text(s);
         if (s.len() > 0) send_text(s);
      end
   endtask

   task automatic test_ipv4_texts();
      string texts[$] = '{"0.0.0.0", "255.255.255.255/32", "1.2.3.4/0",
                          "192.168.001.010/08", "1.2.3.256", "1.2.3.4/33"};
      foreach (texts[i]) send_text(texts[i]);
   endtask

   task automatic test_ipv6_texts();
      string texts[$] = '{"::", "::1", "1::", "ffff:FFFF:0:0:0:0:0:abcd/128",
                          "1:2:3:4:5:6:7:8", "1:2:3:4::5:6:7:8", "1:2:", "::1:",
                          "0000:0000:0000:0000:0000:0000:0000:0000/128"};
      foreach (texts[i]) send_text(texts[i]);
   endtask

   task automatic test_rejected_texts();
      string texts[$] = '{"1", "/5", "1:2:3:4:5:6:7:8:9", "1:::2", ":1", "1::2::3",
                          "12345::", "+1.2.3.4", " ::1", "0x1::", "1.2.3.4/",
                          "::/129", "1..2.3", "1.2.3.4.5",
                          "0000:0000:0000:0000:0000:0000:0000:0000/0128"};
      foreach (texts[i]) send_text(texts[i]);
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      run_random_texts(150);
      no_idle = 1'b0;
   endtask

   task automatic test_random_texts();
      run_random_texts(560);
   endtask

   // Receiver side: random stalls unless a back-to-back stretch is running.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
   end

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result expected none, got %p", $time, rsp_item);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("accepted", 64'(want.accepted), 64'(rsp_item.accepted));
            check_field("is_ipv6", 64'(want.is_ipv6), 64'(rsp_item.is_ipv6));
            check_field("prefix_len", 64'(want.prefix_len), 64'(rsp_item.prefix_len));
            check_field("addr_high", want.addr_high, rsp_item.addr_high);
            check_field("addr_low", want.addr_low, rsp_item.addr_low);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clear_parser();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_ipv4_texts();
      test_ipv6_texts();
      test_rejected_texts();
      test_back_to_back();
      test_random_texts();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/ipatp_pkg.sv
sv/ipatp_front.sv
sv/ipatp_queue.sv
sv/ipatp_back.sv
sv/ip_address_text_parser.sv
sv/ipatp_checker.sv
tb/sv/ip_address_text_parser_tb.sv
